// ===== hdl/crsd_pkg.sv =====
package crsd_pkg;

  localparam int WORD_W          = 32;
  localparam int CFG_W           = 6;
  localparam int BLOCK_BITS_DEF  = 32;
  localparam int MAX_MASKS_DEF   = 64;
  localparam logic [CFG_W-1:0] BLOCK_LEN_RST = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_SCAN,
    ST_KEEP,
    ST_FLUSH
  } crsd_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

  typedef struct packed {
    logic zero;
    logic last;
  } gen_stat_t;

endpackage

// ===== hdl/crsd_ram.sv =====
module crsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/crsd_rotgen.sv =====
module crsd_rotgen
  import crsd_pkg::*;
#(
  parameter int W  = BLOCK_BITS_DEF,
  parameter int LW = $clog2(BLOCK_BITS_DEF + 1),
  parameter int KW = $clog2(BLOCK_BITS_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  gen_ctrl_t     ctrl,
  input  logic [W-1:0]  word,
  input  logic [LW-1:0] len,
  output logic [W-1:0]  cand,
  output gen_stat_t     stat
);

  logic [W-1:0]  f;
  logic [W-1:0]  r;
  logic [W-1:0]  lenmask_q;
  logic [KW-1:0] lm1_q;
  logic [KW-1:0] k;
  logic          pass;

  logic [W-1:0]  lenmask;
  logic [KW-1:0] lm1;
  logic [W-1:0]  word_m;
  logic [W-1:0]  rev;
  logic [W-1:0]  rev_sh;
  logic [LW-1:0] shamt;
  logic [W-1:0]  r_init;
  logic [W-1:0]  f_next;
  logic [W-1:0]  r_next;

  // The forward register steps right and the reflected one steps left,
  // both rotating within the active length.
  always_comb begin
    for (int m = 0; m < W; m++) begin
      lenmask[m] = (LW'(m) < len);
    end
    word_m = word & lenmask;
    for (int m = 0; m < W; m++) begin
      rev[m] = word_m[W-1-m];
    end
    lm1    = KW'(len - LW'(1));
    shamt  = LW'(W) - len;
    rev_sh = rev >> shamt;
    r_init = ((rev_sh << 1) & lenmask) | W'(rev_sh[lm1]);
    f_next = (f >> 1) | (W'(f[0]) << lm1_q);
    r_next = ((r << 1) & lenmask_q) | W'(r[lm1_q]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      pass <= 1'b0;
    end else if (ctrl.load) begin
      k    <= '0;
      pass <= 1'b0;
    end else if (ctrl.step) begin
      if (k == lm1_q) begin
        k    <= '0;
        pass <= 1'b1;
      end else begin
        k <= k + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      lenmask_q <= lenmask;
      lm1_q     <= lm1;
      f         <= word_m;
      r         <= r_init;
    end else if (ctrl.step) begin
      if (pass) begin
        r <= r_next;
      end else begin
        f <= f_next;
      end
    end
  end

  assign cand      = pass ? r : f;
  assign stat.zero = ~cand[0];
  assign stat.last = pass && (k == lm1_q);

endmodule

// ===== hdl/cyclic_rotation_set_dedup_top.sv =====
// Lists the distinct rotations of a cyclic word that start at a zero bit.
// Configuration: cfg_valid/cfg_data write block_len (2..32, clamped); the
// port is always ready and should be written only while the block is idle.
// Input: one word per request on s_tvalid/s_tready/s_tdata. s_tready is high
// only while the block is idle, so one word is processed at a time.
// Output: each distinct mask on m_tdata, in order of first appearance, with
// m_tlast marking the final mask of the word. An all-ones word gives none.
// Per word: the block accepts it, steps through the 2*L candidate positions
// (L = used length), and for each zero position scans the masks kept so far
// at one compare per cycle against the mask RAM, then keeps each new mask;
// after the last candidate position the word closes. The serial compare
// against the mask RAM is the main part of the work for a word.
// Each mask waits in a pending register until the next new mask is kept or
// the word closes, then moves to the output register; a stalled receiver
// holds the sequencer when both are full. After reset block_len is 32, the
// output is empty and the block idle.
module cyclic_rotation_set_dedup_top
  import crsd_pkg::*;
#(
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int MAX_MASKS  = MAX_MASKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,   // block_len
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,    // word_bits
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,    // rotated_mask
  output logic              m_tlast     // last_mask
);

  localparam int W  = BLOCK_BITS;
  localparam int LW = $clog2(BLOCK_BITS + 1);
  localparam int KW = $clog2(BLOCK_BITS);
  localparam int AW = $clog2(MAX_MASKS);
  localparam int CW = $clog2(MAX_MASKS + 1);
  localparam logic [CFG_W-1:0] BlkMax = CFG_W'(BLOCK_BITS);

  crsd_state_t state, state_next;

  logic [CFG_W-1:0] blen;
  logic [LW-1:0]    len_use;
  logic [W-1:0]     gen_word;
  gen_ctrl_t        gctl;
  gen_stat_t        gstat;

  logic [W-1:0]  cand;
  logic          done_q;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [W-1:0]  rdata;
  logic          pend_valid;
  logic [W-1:0]  pend_mask;
  logic [W-1:0]  out_mask;

  logic accept, cap_cand, hit, miss, issue, keep, load_out, out_last_val;
  logic flush_out, out_free, full;

  always_comb begin
    if (blen < CFG_W'(2)) begin
      len_use = LW'(2);
    end else if (blen > BlkMax) begin
      len_use = LW'(BLOCK_BITS);
    end else begin
      len_use = blen[LW-1:0];
    end
  end

  crsd_rotgen #(.W(W), .LW(LW), .KW(KW)) u_rotgen (
    .clk  (clk),
    .rst  (rst),
    .ctrl (gctl),
    .word (s_tdata[W-1:0]),
    .len  (len_use),
    .cand (gen_word),
    .stat (gstat)
  );

  crsd_ram #(.WIDTH(W), .DEPTH(MAX_MASKS)) u_seen (
    .clk   (clk),
    .we    (keep),
    .waddr (count[AW-1:0]),
    .wdata (cand),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign out_free = !m_tvalid || m_tready;
  assign hit      = rd_pend && (rdata == cand);
  assign full     = (count == CW'(MAX_MASKS));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_GEN;
      end
      ST_GEN: begin
        if (gstat.zero) begin
          state_next = ST_SCAN;
        end else if (gstat.last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (hit || (miss && full)) begin
          state_next = done_q ? ST_FLUSH : ST_GEN;
        end else if (miss) begin
          state_next = ST_KEEP;
        end
      end
      ST_KEEP: begin
        if (!pend_valid || out_free) state_next = done_q ? ST_FLUSH : ST_GEN;
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    gctl         = '0;
    cap_cand     = 1'b0;
    issue        = 1'b0;
    miss         = 1'b0;
    keep         = 1'b0;
    load_out     = 1'b0;
    out_last_val = 1'b0;
    flush_out    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        gctl.load = s_tvalid;
      end
      ST_GEN: begin
        gctl.step = 1'b1;
        cap_cand  = gstat.zero;
      end
      ST_SCAN: begin
        issue = !hit && (idx != count);
        miss  = !hit && (idx == count);
      end
      ST_KEEP: begin
        keep     = !pend_valid || out_free;
        load_out = pend_valid && out_free;
      end
      ST_FLUSH: begin
        flush_out    = pend_valid && out_free;
        load_out     = flush_out;
        out_last_val = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      blen       <= BLOCK_LEN_RST;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
      rd_pend    <= 1'b0;
      count      <= '0;
      idx        <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cfg_valid && cfg_ready) blen <= cfg_data;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        count      <= '0;
        pend_valid <= 1'b0;
      end
      if (cap_cand) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + CW'(1);
      end
      if (keep) begin
        count      <= count + CW'(1);
        pend_valid <= 1'b1;
      end
      if (flush_out) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_cand) begin
      cand   <= gen_word;
      done_q <= gstat.last;
    end
    if (keep) pend_mask <= cand;
    if (load_out) begin
      out_mask <= pend_mask;
      m_tlast  <= out_last_val;
    end
  end

  assign m_tdata = WORD_W'(out_mask);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_MASKS))
    else $error("kept mask count exceeds the store depth");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= count))
    else $error("scan index ran past the kept masks");

  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (count != '0))
    else $error("mask store read with no kept masks");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (load_out && out_last_val) |=> (!pend_valid && m_tvalid && m_tlast))
    else $error("final mask did not close the word");
`endif

endmodule

// ===== verif/cyclic_rotation_set_dedup_top_tb.sv =====
`timescale 1ns / 1ps

module cyclic_rotation_set_dedup_top_tb;
  import crsd_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int WORDS_PER_PHASE = 28;
  localparam int N_PHASES = 12;

  typedef struct {
    logic [WORD_W-1:0] mask;
    logic              last;
  } mask_res_t;

  class mask_board;
    logic [CFG_W-1:0] block_len;
    mask_res_t        expected_masks[$];
    int               mismatches;

    function new();
      block_len = BLOCK_LEN_RST;
      mismatches = 0;
    endfunction

    function void set_len(logic [CFG_W-1:0] v);
      block_len = v;
    endfunction

    function int used_len();
      int n;
      n = block_len;
      if (n < 2) n = 2;
      if (n > BLOCK_BITS_DEF) n = BLOCK_BITS_DEF;
      return n;
    endfunction

    // Forward rotations at each zero position, then reflected ones, keeping
    // only the first appearance of each mask.
    function void note_word(logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] kept[$];
      logic [WORD_W-1:0] mask;
      mask_res_t         r;
      int                n;
      int                pos;
      bit                dup;
      n = used_len();
      for (int pass = 0; pass < 2; pass++) begin
        for (int k = 0; k < n; k++) begin
          if (w[k]) continue;
          mask = '0;
          for (int m = 0; m < n; m++) begin
            pos = (pass == 0) ? (k + m) % n : (k - m + n) % n;
            if (w[pos]) mask[m] = 1'b1;
          end
          dup = 1'b0;
          foreach (kept[i]) if (kept[i] == mask) dup = 1'b1;
          if (!dup && kept.size() < MAX_MASKS_DEF) kept.push_back(mask);
        end
      end
      foreach (kept[i]) begin
        r.mask = kept[i];
        r.last = (i == kept.size() - 1);
        expected_masks.push_back(r);
      end
    endfunction

    function void check_mask(logic [WORD_W-1:0] d, logic l);
      mask_res_t e;
      if (expected_masks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected mask %h last %b", d, l);
        return;
      end
      e = expected_masks.pop_front();
      if (d !== e.mask || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mask error: expected %h last %b, got %h last %b",
                   e.mask, e.last, d, l);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;
  logic              m_tlast;

  mask_board board;
  bit        quiet;
  int        stall_left = 0;
  int        idle_cycles = 0;

  cyclic_rotation_set_dedup_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [WORD_W-1:0] make_word(int n);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] pat;
    int                mode;
    int                p;
    bit                fill;
    w = $urandom;
    mode = $urandom_range(0, 9);
    if (mode >= 3 && mode <= 4) begin
      for (int i = 0; i < n; i++) w[i] = 1'b1;
      repeat ($urandom_range(1, 3)) w[$urandom_range(0, n - 1)] = 1'b0;
    end else if (mode >= 5 && mode <= 6) begin
      pat = $urandom;
      p = $urandom_range(1, n);
      for (int i = 0; i < n; i++) w[i] = pat[i % p];
    end else if (mode == 7) begin
      for (int i = 0; i < n; i++) if (i < n - 1 - i) w[n - 1 - i] = w[i];
    end else if (mode == 8) begin
      w = $urandom & $urandom & $urandom;
    end else if (mode == 9) begin
      fill = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) w[i] = fill;
    end
    return w;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    board.note_word(w);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.expected_masks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [CFG_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_len(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rst && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_mask(m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] seed_words [13] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000,
      32'h0F0F_0F0F, 32'h1234_5678, 32'hFFFF_0000, 32'hDEAD_BEEF,
      32'h0001_0001
    };
    logic [CFG_W-1:0] phase_lens [N_PHASES] = '{
      6'd2, 6'd1, 6'd63, 6'd3, 6'd5, 6'd8, 6'd13, 6'd20, 6'd31, 6'd32,
      6'd0, 6'd0
    };
    logic [CFG_W-1:0] len;
    board = new();
    quiet = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (seed_words[i]) send_word(seed_words[i]);

    // Upper bits are ignored: all ones, all zeros, a single zero and a mixed pattern in the used field.
    write_len(6'd8);
    send_word(32'h0000_00FF);
    send_word(32'hFFFF_FF00);
    send_word(32'hFFFF_FF7F);
    send_word(32'h0000_005A);

    // Lengths below two and above the word width are clamped.
    write_len(6'd0);
    send_word(32'h0000_0003);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFD);
    send_word(32'h0000_0002);
    write_len(6'd33);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);

    for (int p = 0; p < N_PHASES; p++) begin
      len = (p >= 10) ? 6'($urandom_range(0, 63)) : phase_lens[p];
      write_len(len);
      quiet = (p % 4 == 1);
      repeat (WORDS_PER_PHASE) send_word(make_word(board.used_len()));
    end
    quiet = 1'b0;

    wait_drained();
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
